// ===== rtl/core/cvi_pkg.sv =====
// Package: word types, widths and outcome codes of the contact impulse block.
package cvi_pkg;

  localparam int VEL_W = 32;
  localparam int NRM_W = 16;
  localparam int MASS_W = 31;
  localparam int REST_W = 17;
  localparam logic [REST_W-1:0] REST_ONE = 17'h10000;

  typedef enum logic [1:0] {
    OUT_SEPARATING = 2'd0,
    OUT_NO_MASS    = 2'd1,
    OUT_IMPULSE    = 2'd2
  } cvi_outcome_t;

  typedef struct packed {
    logic signed [VEL_W-1:0]  first_vel_x;
    logic signed [VEL_W-1:0]  first_vel_y;
    logic signed [VEL_W-1:0]  first_vel_z;
    logic signed [VEL_W-1:0]  second_vel_x;
    logic signed [VEL_W-1:0]  second_vel_y;
    logic signed [VEL_W-1:0]  second_vel_z;
    logic signed [NRM_W-1:0]  normal_x;
    logic signed [NRM_W-1:0]  normal_y;
    logic signed [NRM_W-1:0]  normal_z;
    logic [MASS_W-1:0]        first_inv_mass;
    logic [MASS_W-1:0]        second_inv_mass;
    logic                     has_second;
  } cvi_in_t;

  typedef struct packed {
    logic signed [VEL_W-1:0]  new_first_vel_x;
    logic signed [VEL_W-1:0]  new_first_vel_y;
    logic signed [VEL_W-1:0]  new_first_vel_z;
    logic signed [VEL_W-1:0]  new_second_vel_x;
    logic signed [VEL_W-1:0]  new_second_vel_y;
    logic signed [VEL_W-1:0]  new_second_vel_z;
    cvi_outcome_t             outcome;
  } cvi_out_t;

endpackage

// ===== rtl/core/contact_velocity_impulse.sv =====
// Top level: pipelined particle contact impulse resolution.
// Throughput: one contact per cycle; the mass-share divider is a 4-bit-per-stage
//   restoring pipeline of 8 stages that sets the depth.
// busy stays low; results are shown for one cycle and cannot be stalled.
// Reset clears all stage valid bits and sets restitution to 1.0.
module contact_velocity_impulse (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  cvi_pkg::cvi_in_t                    in_word,
  output logic                                out_strobe,
  output cvi_pkg::cvi_out_t                   out_word,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [cvi_pkg::REST_W-1:0]          cfg_data
);

  localparam int W = cvi_pkg::VEL_W;
  localparam int EW = (W > 40) ? W : 40;
  localparam int REL_W = 41;
  localparam int PROD_W = 57;
  localparam int DOT_W = 59;
  localparam int S_W = 58;
  localparam int VS_W = 44;
  localparam int E_W = 18;
  localparam int DVP_W = 62;
  localparam int DV_W = 46;
  localparam int QP_W = 62;
  localparam int Q_W = 48;
  localparam int R_W = 33;
  localparam int PH_W = 65;
  localparam int PL_W = 64;
  localparam int T_W = 66;
  localparam int D_W = 50;
  localparam int SUM_W = ((W > D_W + 1) ? W : D_W + 1) + 1;
  localparam int TOT_W = cvi_pkg::MASS_W + 1;
  localparam int DIV_BITS = 4;
  localparam int DIV_STAGES = TOT_W / DIV_BITS;

  localparam int S_DOT = 1;
  localparam int S_VS = 2;
  localparam int S_DV = 3;
  localparam int S_QR = 4;
  localparam int S_SHARE = DIV_STAGES + 1;
  localparam int S_DELTA = S_SHARE + 1;
  localparam int S_OUT = S_DELTA + 1;
  localparam int NS = S_OUT + 1;

  localparam logic signed [EW-1:0] CMAX = EW'(64'sh7F_FFFF_FFFF);
  localparam logic signed [EW-1:0] CMIN = EW'(-64'sh80_0000_0000);
  localparam logic signed [SUM_W-1:0] VMAX = SUM_W'({1'b0, {(W-1){1'b1}}});
  localparam logic signed [SUM_W-1:0] VMIN = -VMAX - SUM_W'(1);

  typedef struct packed {
    logic                          valid;
    logic                          two;
    logic [2:0][W-1:0]             va;
    logic [2:0][W-1:0]             vb;
    logic [2:0]                    neg;
    logic [2:0][cvi_pkg::NRM_W-1:0] an;
    logic [2:0][PROD_W-1:0]        prod;
    logic                          zero_mass;
    logic [TOT_W-1:0]              tot;
    logic [TOT_W-1:0]              rem;
    logic [R_W-1:0]                quo;
    logic [DOT_W-1:0]              dot;
    cvi_pkg::cvi_outcome_t         outcome;
    logic [DVP_W-1:0]              vs_p;
    logic [2:0][QP_W-1:0]          dvq;
    logic [2:0][Q_W-1:0]           q;
    logic [2:0][PH_W-1:0]          ph_a;
    logic [2:0][PL_W-1:0]          pl_a;
    logic [2:0][PH_W-1:0]          ph_b;
    logic [2:0][PL_W-1:0]          pl_b;
    logic [2:0][D_W-1:0]           delta_a;
    logic [2:0][D_W-1:0]           delta_b;
    logic [2:0][W-1:0]             na;
    logic [2:0][W-1:0]             nb;
  } st_t;

  st_t st_r [NS];
  st_t st_nxt [NS];
  logic [cvi_pkg::REST_W-1:0] rest_r;

  function automatic logic signed [39:0] clamp40(input logic [W-1:0] v);
    logic signed [EW-1:0] x;
    x = EW'($signed(v));
    if (x > CMAX) x = CMAX;
    if (x < CMIN) x = CMIN;
    return 40'(x);
  endfunction

  function automatic logic [W-1:0] sat(input logic signed [SUM_W-1:0] s);
    if (s > VMAX) return W'(VMAX);
    if (s < VMIN) return W'(VMIN);
    return W'(s);
  endfunction

  assign busy = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rest_r <= cvi_pkg::REST_ONE;
    end else if (cfg_valid && cfg_ready) begin
      rest_r <= cfg_data;
    end
  end

  always_comb begin
    logic signed [REL_W-1:0] rel;
    logic signed [cvi_pkg::NRM_W-1:0] nn;
    logic [cvi_pkg::MASS_W-1:0] mb;
    logic [TOT_W:0] r2;
    logic [S_W-1:0] s;
    logic [S_W-1:0] s_rnd;
    logic [VS_W-1:0] vs;
    logic [E_W-1:0] fac;
    logic [DVP_W-1:0] dv_rnd;
    logic [DV_W-1:0] dv;
    logic [QP_W-1:0] q_rnd;
    logic [R_W-1:0] ra;
    logic [R_W-1:0] rb;
    logic [T_W-1:0] ta;
    logic [T_W-1:0] tb;
    logic signed [SUM_W-1:0] da;
    logic signed [SUM_W-1:0] db;
    logic signed [SUM_W-1:0] sa;
    logic signed [SUM_W-1:0] sb;

    st_nxt[0] = st_r[0];
    for (int k = 1; k < NS; k++) st_nxt[k] = st_r[k-1];

    st_nxt[0].valid = start && !busy;
    st_nxt[0].two = in_word.has_second;
    st_nxt[0].va = {in_word.first_vel_z, in_word.first_vel_y, in_word.first_vel_x};
    st_nxt[0].vb = in_word.has_second ?
                   {in_word.second_vel_z, in_word.second_vel_y, in_word.second_vel_x} :
                   '0;
    for (int i = 0; i < 3; i++) begin
      nn = (i == 0) ? in_word.normal_x : ((i == 1) ? in_word.normal_y : in_word.normal_z);
      st_nxt[0].neg[i] = nn[cvi_pkg::NRM_W-1];
      st_nxt[0].an[i] = nn[cvi_pkg::NRM_W-1] ? cvi_pkg::NRM_W'(-nn) : cvi_pkg::NRM_W'(nn);
      rel = REL_W'(clamp40(st_nxt[0].va[i])) - REL_W'(clamp40(st_nxt[0].vb[i]));
      st_nxt[0].prod[i] = PROD_W'(rel * nn);
    end
    mb = in_word.has_second ? in_word.second_inv_mass : '0;
    st_nxt[0].tot = TOT_W'(in_word.first_inv_mass) + TOT_W'(mb);
    st_nxt[0].zero_mass = (st_nxt[0].tot == '0);
    if (TOT_W'(in_word.first_inv_mass) >= st_nxt[0].tot) begin
      st_nxt[0].quo = R_W'(1);
      st_nxt[0].rem = TOT_W'(in_word.first_inv_mass) - st_nxt[0].tot;
    end else begin
      st_nxt[0].quo = '0;
      st_nxt[0].rem = TOT_W'(in_word.first_inv_mass);
    end

    for (int k = 1; k <= DIV_STAGES; k++) begin
      for (int j = 0; j < DIV_BITS; j++) begin
        r2 = {st_nxt[k].rem, 1'b0};
        if (r2 >= {1'b0, st_nxt[k].tot}) begin
          st_nxt[k].rem = TOT_W'(r2 - {1'b0, st_nxt[k].tot});
          st_nxt[k].quo = {st_nxt[k].quo[R_W-2:0], 1'b1};
        end else begin
          st_nxt[k].rem = TOT_W'(r2);
          st_nxt[k].quo = {st_nxt[k].quo[R_W-2:0], 1'b0};
        end
      end
    end

    st_nxt[S_DOT].dot = DOT_W'($signed(st_r[S_DOT-1].prod[0]))
                      + DOT_W'($signed(st_r[S_DOT-1].prod[1]))
                      + DOT_W'($signed(st_r[S_DOT-1].prod[2]));
    if ($signed(st_nxt[S_DOT].dot) > 0) begin
      st_nxt[S_DOT].outcome = cvi_pkg::OUT_SEPARATING;
    end else if (st_r[S_DOT-1].zero_mass) begin
      st_nxt[S_DOT].outcome = cvi_pkg::OUT_NO_MASS;
    end else begin
      st_nxt[S_DOT].outcome = cvi_pkg::OUT_IMPULSE;
    end

    s = S_W'(-st_r[S_VS-1].dot);
    s_rnd = s + S_W'(14'h2000);
    vs = s_rnd[S_W-1:14];
    fac = E_W'(cvi_pkg::REST_ONE)
        + ((rest_r > cvi_pkg::REST_ONE) ? E_W'(cvi_pkg::REST_ONE) : E_W'(rest_r));
    st_nxt[S_VS].vs_p = DVP_W'(vs) * DVP_W'(fac);

    dv_rnd = st_r[S_DV-1].vs_p + DVP_W'(16'h8000);
    dv = dv_rnd[DVP_W-1:16];
    for (int i = 0; i < 3; i++) begin
      st_nxt[S_DV].dvq[i] = QP_W'(dv) * QP_W'(st_r[S_DV-1].an[i]);
    end

    for (int i = 0; i < 3; i++) begin
      q_rnd = st_r[S_QR-1].dvq[i] + QP_W'(14'h2000);
      st_nxt[S_QR].q[i] = q_rnd[QP_W-1:14];
    end

    ra = st_r[S_SHARE-1].quo;
    rb = R_W'(33'h1_0000_0000) - ra - R_W'(st_r[S_SHARE-1].rem != '0);
    for (int i = 0; i < 3; i++) begin
      st_nxt[S_SHARE].ph_a[i] = PH_W'(st_r[S_SHARE-1].q[i]) * PH_W'(ra[R_W-1:16]);
      st_nxt[S_SHARE].pl_a[i] = PL_W'(st_r[S_SHARE-1].q[i]) * PL_W'(ra[15:0]);
      st_nxt[S_SHARE].ph_b[i] = PH_W'(st_r[S_SHARE-1].q[i]) * PH_W'(rb[R_W-1:16]);
      st_nxt[S_SHARE].pl_b[i] = PL_W'(st_r[S_SHARE-1].q[i]) * PL_W'(rb[15:0]);
    end

    for (int i = 0; i < 3; i++) begin
      ta = T_W'(st_r[S_DELTA-1].ph_a[i]) + T_W'(st_r[S_DELTA-1].pl_a[i][PL_W-1:16])
         + T_W'(16'h8000);
      tb = T_W'(st_r[S_DELTA-1].ph_b[i]) + T_W'(st_r[S_DELTA-1].pl_b[i][PL_W-1:16])
         + T_W'(16'h8000);
      st_nxt[S_DELTA].delta_a[i] = ta[T_W-1:16];
      st_nxt[S_DELTA].delta_b[i] = tb[T_W-1:16];
    end

    for (int i = 0; i < 3; i++) begin
      da = $signed(SUM_W'(st_r[S_OUT-1].delta_a[i]));
      db = $signed(SUM_W'(st_r[S_OUT-1].delta_b[i]));
      if (st_r[S_OUT-1].neg[i]) begin
        sa = SUM_W'($signed(st_r[S_OUT-1].va[i])) - da;
        sb = SUM_W'($signed(st_r[S_OUT-1].vb[i])) + db;
      end else begin
        sa = SUM_W'($signed(st_r[S_OUT-1].va[i])) + da;
        sb = SUM_W'($signed(st_r[S_OUT-1].vb[i])) - db;
      end
      if (st_r[S_OUT-1].outcome == cvi_pkg::OUT_IMPULSE) begin
        st_nxt[S_OUT].na[i] = sat(sa);
        st_nxt[S_OUT].nb[i] = st_r[S_OUT-1].two ? sat(sb) : '0;
      end else begin
        st_nxt[S_OUT].na[i] = st_r[S_OUT-1].va[i];
        st_nxt[S_OUT].nb[i] = st_r[S_OUT-1].vb[i];
      end
    end

    if (!rst_n) begin
      for (int k = 0; k < NS; k++) st_nxt[k].valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    st_r <= st_nxt;
  end

  assign out_strobe = st_r[S_OUT].valid;
  assign out_word.new_first_vel_x = st_r[S_OUT].na[0];
  assign out_word.new_first_vel_y = st_r[S_OUT].na[1];
  assign out_word.new_first_vel_z = st_r[S_OUT].na[2];
  assign out_word.new_second_vel_x = st_r[S_OUT].nb[0];
  assign out_word.new_second_vel_y = st_r[S_OUT].nb[1];
  assign out_word.new_second_vel_z = st_r[S_OUT].nb[2];
  assign out_word.outcome = st_r[S_OUT].outcome;

  a_pass_through: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_word.outcome != cvi_pkg::OUT_IMPULSE
    |-> out_word.new_first_vel_x == $past(in_word.first_vel_x, NS))
    else $error("velocity changed without impulse");

  a_no_second: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !$past(in_word.has_second, NS)
    |-> out_word.new_second_vel_x == '0 && out_word.new_second_vel_y == '0
        && out_word.new_second_vel_z == '0)
    else $error("second velocity not zero without second particle");

  a_immovable: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && $past(in_word.first_inv_mass, NS) == '0
    |-> out_word.new_first_vel_y == $past(in_word.first_vel_y, NS))
    else $error("immovable particle moved");

endmodule

// ===== tb/contact_velocity_impulse_chk.sv =====
// Checker: predicts each contact impulse result and compares it with the block's output.
`timescale 1ns / 100ps
module contact_velocity_impulse_chk (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic                         busy,
  input  cvi_pkg::cvi_in_t             in_word,
  input  logic                         out_strobe,
  input  cvi_pkg::cvi_out_t            out_word,
  input  logic                         cfg_valid,
  input  logic                         cfg_ready,
  input  logic [cvi_pkg::REST_W-1:0]   cfg_data,
  output int                           fail_count,
  output int                           pending
);

  logic [cvi_pkg::REST_W-1:0] rest_q;
  cvi_pkg::cvi_out_t expected_words[$];

  function automatic logic [63:0] share_scale(logic [63:0] q, logic [63:0] r);
    logic [63:0] t;
    t = q * (r >> 16) + ((q * (r & 64'hFFFF)) >> 16);
    return (t + 64'h8000) >> 16;
  endfunction

  function automatic logic signed [cvi_pkg::VEL_W-1:0] add_sat(longint a, longint d);
    longint s;
    s = a + d;
    if (s > 64'sd2147483647) s = 64'sd2147483647;
    if (s < -64'sd2147483648) s = -64'sd2147483648;
    return s[cvi_pkg::VEL_W-1:0];
  endfunction

  function automatic cvi_pkg::cvi_out_t resolve_contact(cvi_pkg::cvi_in_t w,
                                                        logic [cvi_pkg::REST_W-1:0] rest);
    cvi_pkg::cvi_out_t r;
    longint va[3], vb[3], nv[3], dot, da, db;
    logic [63:0] ma, mb, tot, vs, e, dv, ra, rb, an, q;
    va[0] = w.first_vel_x; va[1] = w.first_vel_y; va[2] = w.first_vel_z;
    vb[0] = w.has_second ? longint'(w.second_vel_x) : 0;
    vb[1] = w.has_second ? longint'(w.second_vel_y) : 0;
    vb[2] = w.has_second ? longint'(w.second_vel_z) : 0;
    nv[0] = w.normal_x; nv[1] = w.normal_y; nv[2] = w.normal_z;
    ma = w.first_inv_mass;
    mb = w.has_second ? 64'(w.second_inv_mass) : 0;
    dot = 0;
    for (int i = 0; i < 3; i++) dot += (va[i] - vb[i]) * nv[i];
    if (dot > 0) begin
      r.outcome = cvi_pkg::OUT_SEPARATING;
    end else if (ma + mb == 0) begin
      r.outcome = cvi_pkg::OUT_NO_MASS;
    end else begin
      r.outcome = cvi_pkg::OUT_IMPULSE;
      tot = ma + mb;
      vs = (64'(-dot) + 64'h2000) >> 14;
      e = (rest > cvi_pkg::REST_ONE) ? 64'(cvi_pkg::REST_ONE) : 64'(rest);
      dv = (vs * (64'h10000 + e) + 64'h8000) >> 16;
      ra = (ma << 32) / tot;
      rb = (mb << 32) / tot;
      for (int i = 0; i < 3; i++) begin
        an = (nv[i] < 0) ? 64'(-nv[i]) : 64'(nv[i]);
        q = (dv * an + 64'h2000) >> 14;
        da = share_scale(q, ra);
        db = share_scale(q, rb);
        if (nv[i] < 0) begin
          da = -da;
          db = -db;
        end
        va[i] = add_sat(va[i], da);
        vb[i] = add_sat(vb[i], -db);
      end
    end
    r.new_first_vel_x = va[0][cvi_pkg::VEL_W-1:0];
    r.new_first_vel_y = va[1][cvi_pkg::VEL_W-1:0];
    r.new_first_vel_z = va[2][cvi_pkg::VEL_W-1:0];
    r.new_second_vel_x = w.has_second ? vb[0][cvi_pkg::VEL_W-1:0] : '0;
    r.new_second_vel_y = w.has_second ? vb[1][cvi_pkg::VEL_W-1:0] : '0;
    r.new_second_vel_z = w.has_second ? vb[2][cvi_pkg::VEL_W-1:0] : '0;
    return r;
  endfunction

  assign pending = expected_words.size();

  always @(posedge clk) begin
    cvi_pkg::cvi_out_t exp_w;
    if (!rst_n) begin
      rest_q <= cvi_pkg::REST_ONE;
      fail_count <= 0;
      expected_words.delete();
    end else begin
      if (cfg_valid && cfg_ready) rest_q <= cfg_data;
      if (start && !busy) expected_words.push_back(resolve_contact(in_word, rest_q));
      if (out_strobe) begin
        if (expected_words.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10) $display("unexpected word %h", out_word);
        end else begin
          exp_w = expected_words.pop_front();
          if (out_word !== exp_w) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10) $display("mismatch exp %h got %h", exp_w, out_word);
          end
        end
      end
    end
  end

endmodule

// ===== tb/contact_velocity_impulse_tb.sv =====
// Testbench top: drives contacts and restitution settings into the impulse block.
`timescale 1ns / 100ps
module contact_velocity_impulse_tb;

  localparam int LATENCY = 12;
  localparam int WATCHDOG = 2000;

  logic clk, rst_n, start, busy, out_strobe, cfg_valid, cfg_ready;
  cvi_pkg::cvi_in_t in_word;
  cvi_pkg::cvi_out_t out_word;
  logic [cvi_pkg::REST_W-1:0] cfg_data;
  int fail_count, pending, idle_cycles;

  contact_velocity_impulse dut (.*);
  contact_velocity_impulse_chk chk (.*);

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic logic signed [cvi_pkg::VEL_W-1:0] rand_vel();
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? 32'sh7FFFFFFF - $urandom_range(0, 65535)
                                     : 32'sh80000000 + $urandom_range(0, 65535);
      default: return $signed($urandom_range(0, 32'h01FFFFFF)) - 32'sh00FFFFFF;
    endcase
  endfunction

  function automatic logic signed [cvi_pkg::NRM_W-1:0] rand_nrm();
    case ($urandom_range(0, 3))
      0: return 16'($urandom);
      1: return $urandom_range(0, 1) ? 16'sh4000 : -16'sh4000;
      default: return $signed(16'($urandom_range(0, 32767))) - 16'sh4000;
    endcase
  endfunction

  function automatic logic [cvi_pkg::MASS_W-1:0] rand_mass();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return 31'($urandom);
      2: return 31'h7FFFFFFF;
      default: return 31'($urandom_range(1, 32'h0004_0000));
    endcase
  endfunction

  function automatic cvi_pkg::cvi_in_t rand_contact();
    cvi_pkg::cvi_in_t w;
    w.first_vel_x = rand_vel(); w.first_vel_y = rand_vel(); w.first_vel_z = rand_vel();
    w.second_vel_x = rand_vel(); w.second_vel_y = rand_vel(); w.second_vel_z = rand_vel();
    w.normal_x = rand_nrm(); w.normal_y = rand_nrm(); w.normal_z = rand_nrm();
    w.first_inv_mass = rand_mass();
    w.second_inv_mass = rand_mass();
    w.has_second = $urandom_range(0, 3) != 0;
    return w;
  endfunction

  task automatic send_contact(cvi_pkg::cvi_in_t w, bit allow_gap);
    int gap;
    gap = allow_gap ? $urandom_range(0, 16) : 0;
    if (gap > 0 && $urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_restitution(logic [cvi_pkg::REST_W-1:0] value);
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    cvi_pkg::cvi_in_t w;
    logic [cvi_pkg::REST_W-1:0] rest_vals[6];
    rest_vals = '{17'h0, 17'h10000, 17'h1FFFF, 17'h08000, 17'h10001, 17'h0};
    rst_n = 0; start = 0; cfg_valid = 0; cfg_data = '0; in_word = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed contacts first, then random contacts
    for (int k = 0; k < 20; k++) begin
      w = rand_contact();
      case (k)
        0: begin w = '0; w.normal_x = 16'sh4000; w.first_inv_mass = 31'd1; end
        1: begin w.first_vel_x = 32'sh80000000; w.normal_x = 16'sh4000; w.has_second = 0;
                 w.first_inv_mass = 31'h7FFFFFFF; end
        2: begin w.first_vel_y = 32'sh7FFFFFFF; w.second_vel_y = 32'sh80000000;
                 w.normal_y = -16'sh8000; w.has_second = 1; end
        3: begin w.first_inv_mass = '0; w.second_inv_mass = '0; end
        4: begin w.first_inv_mass = '0; w.has_second = 0; w.first_vel_z = 32'sh80000000;
                 w.normal_z = 16'sh7FFF; end
        5: begin w.normal_x = 16'sh7FFF; w.normal_y = -16'sh8000; w.normal_z = 16'sh7FFF; end
        6: begin w = '1; end
        7: begin w.has_second = 1; w.first_inv_mass = 31'h7FFFFFFF;
                 w.second_inv_mass = 31'h7FFFFFFF; end
        default: ;
      endcase
      send_contact(w, 1'b0);
    end

    for (int p = 0; p < 6; p++) begin
      write_restitution(rest_vals[p]);
      for (int k = 0; k < 125; k++) send_contact(rand_contact(), p != 2);
    end
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
    if (fail_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
